// ===== rtl/sha1s_pkg.sv =====
// Shared types and constants of the SHA-1 stream hasher.
`default_nettype none
package sha1s_pkg;

   localparam int WordW      = 32;
   localparam int NumDigest  = 5;
   localparam int WindowLen  = 16;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int CntW       = 61;   // byte count; bit length is this times 8

   typedef logic [WordW-1:0] word_type;

   // queue entry: a block word, or the command to emit the digest
   typedef struct packed {
      logic     is_digest;
      word_type word;
   } q_entry_type;

   typedef struct packed {
      logic [63:0] initial_ab;
      logic [63:0] initial_cd;
      logic [31:0] initial_e;
      logic [63:0] round_const_01;
      logic [63:0] round_const_23;
   } cfg_type;

   localparam logic [2:0] CSR_INITIAL_AB     = 3'd0;
   localparam logic [2:0] CSR_INITIAL_CD     = 3'd1;
   localparam logic [2:0] CSR_INITIAL_E      = 3'd2;
   localparam logic [2:0] CSR_ROUND_CONST_01 = 3'd3;
   localparam logic [2:0] CSR_ROUND_CONST_23 = 3'd4;

   localparam word_type   PAD_MARK      = 32'h8000_0000;
   localparam logic [3:0] LEN_HI_SLOT   = 4'd14;
   localparam logic [6:0] SCHED_LOADED  = 7'd16;
   localparam logic [6:0] PHASE1_START  = 7'd20;
   localparam logic [6:0] PHASE2_START  = 7'd40;
   localparam logic [6:0] PHASE3_START  = 7'd60;
   localparam logic [6:0] LAST_ROUND    = 7'd79;
   localparam logic [2:0] LAST_WORD_IDX = 3'(NumDigest - 1);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_MARK,
      FR_ZERO,
      FR_LEN_LO,
      FR_DIGEST
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_FOLD,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/sha1s_fifo.sv =====
// Short word queue between the byte packer and the compression engine.
`default_nettype none
module sha1s_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire sha1s_pkg::q_entry_type wdata,
   output logic                        full,
   input  wire logic                   pop,
   output sha1s_pkg::q_entry_type      rdata,
   output logic                        empty
);

   sha1s_pkg::q_entry_type          mem_ff [sha1s_pkg::QueueDepth];
   logic [sha1s_pkg::QPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sha1s_pkg::QPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sha1s_pkg::QPtrW:0]       count_ff, count_in;

   assign full  = (count_ff == (sha1s_pkg::QPtrW+1)'(sha1s_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sha1s_pkg::QPtrW'(sha1s_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sha1s_pkg::QPtrW'(sha1s_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sha1s_front.sv =====
// Front end: takes bytes, packs big-endian words, generates padding and length.
`default_nettype none
module sha1s_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_byte_present,
   input  wire logic                   req_end_of_message,
   output logic                        q_push,
   output sha1s_pkg::q_entry_type      q_wdata,
   input  wire logic                   q_full
);

   sha1s_pkg::front_state_type   state_ff, state_in;
   logic [sha1s_pkg::CntW-1:0]   cnt_ff, cnt_in;
   logic [23:0]                  acc_ff, acc_in;
   logic [3:0]                   pad_ff, pad_in;
   logic [1:0]                   lane;
   logic [63:0]                  bit_len;

   assign lane    = cnt_ff[1:0];
   assign bit_len = {cnt_ff, 3'b000};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      pad_in    = pad_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      q_wdata   = '0;
      unique case (state_ff)
         sha1s_pkg::FR_IDLE: begin
            req_ready = !q_full;
            if (req_valid && !q_full) begin
               if (req_byte_present) begin
                  cnt_in = cnt_ff + 1'b1;
                  unique case (lane)
                     2'd0: acc_in[23:16] = req_data_byte;
                     2'd1: acc_in[15:8]  = req_data_byte;
                     2'd2: acc_in[7:0]   = req_data_byte;
                     default: begin
                        q_push       = 1'b1;
                        q_wdata.word = {acc_ff, req_data_byte};
                        acc_in       = '0;
                     end
                  endcase
               end
               if (req_end_of_message) begin
                  state_in = sha1s_pkg::FR_MARK;
               end
            end
         end
         sha1s_pkg::FR_MARK: begin
            if (!q_full) begin
               q_push       = 1'b1;
               q_wdata.word = {acc_ff, 8'h00} | (sha1s_pkg::PAD_MARK >> {lane, 3'b000});
               pad_in       = cnt_ff[5:2] + 1'b1;
               state_in     = sha1s_pkg::FR_ZERO;
            end
         end
         sha1s_pkg::FR_ZERO: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (pad_ff == sha1s_pkg::LEN_HI_SLOT) begin
                  q_wdata.word = bit_len[63:32];
                  state_in     = sha1s_pkg::FR_LEN_LO;
               end else begin
                  pad_in = pad_ff + 1'b1;   // wraps into a second block if needed
               end
            end
         end
         sha1s_pkg::FR_LEN_LO: begin
            if (!q_full) begin
               q_push       = 1'b1;
               q_wdata.word = bit_len[31:0];
               state_in     = sha1s_pkg::FR_DIGEST;
            end
         end
         sha1s_pkg::FR_DIGEST: begin
            if (!q_full) begin
               q_push            = 1'b1;
               q_wdata.is_digest = 1'b1;
               cnt_in            = '0;
               acc_in            = '0;
               state_in          = sha1s_pkg::FR_IDLE;
            end
         end
         default: state_in = sha1s_pkg::FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1s_pkg::FR_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         pad_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         pad_ff   <= pad_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sha1s_back.sv =====
// Back end: 80-round compression, chaining value fold and digest output register.
`default_nettype none
module sha1s_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sha1s_pkg::cfg_type     cfg,
   input  wire logic                   q_empty,
   input  wire sha1s_pkg::q_entry_type q_rdata,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [31:0]                 rsp_digest_word,
   output logic [2:0]                  rsp_word_index,
   output logic                        rsp_last_word
);

   sha1s_pkg::back_state_type state_ff, state_in;
   logic [6:0]           rnd_ff, rnd_in;
   logic                 fresh_ff, fresh_in;
   logic [2:0]           emit_ff, emit_in;
   sha1s_pkg::word_type  work_ff  [sha1s_pkg::NumDigest];
   sha1s_pkg::word_type  work_in  [sha1s_pkg::NumDigest];
   sha1s_pkg::word_type  chain_ff [sha1s_pkg::NumDigest];
   sha1s_pkg::word_type  chain_in [sha1s_pkg::NumDigest];
   sha1s_pkg::word_type  win_ff   [sha1s_pkg::WindowLen];
   sha1s_pkg::word_type  win_in   [sha1s_pkg::WindowLen];
   sha1s_pkg::word_type  init_cv  [sha1s_pkg::NumDigest];
   logic                 rsp_valid_ff, rsp_valid_in;
   sha1s_pkg::word_type  rsp_word_ff, rsp_word_in;
   logic [2:0]           rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;

   sha1s_pkg::word_type  w_mix, wt, f, k, t;
   logic                 loading, do_round, out_free;

   assign init_cv[0] = cfg.initial_ab[63:32];
   assign init_cv[1] = cfg.initial_ab[31:0];
   assign init_cv[2] = cfg.initial_cd[63:32];
   assign init_cv[3] = cfg.initial_cd[31:0];
   assign init_cv[4] = cfg.initial_e;

   // window holds w[r-16] at index 0 up to w[r-1] at index 15
   assign w_mix   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign loading = (rnd_ff < sha1s_pkg::SCHED_LOADED);
   assign wt      = loading ? q_rdata.word : {w_mix[30:0], w_mix[31]};

   always_comb begin
      priority if (rnd_ff < sha1s_pkg::PHASE1_START) begin
         f = (work_ff[1] & work_ff[2]) ^ (~work_ff[1] & work_ff[3]);
         k = cfg.round_const_01[63:32];
      end else if (rnd_ff < sha1s_pkg::PHASE2_START) begin
         f = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k = cfg.round_const_01[31:0];
      end else if (rnd_ff < sha1s_pkg::PHASE3_START) begin
         f = (work_ff[1] & work_ff[2]) ^ (work_ff[1] & work_ff[3]) ^
             (work_ff[2] & work_ff[3]);
         k = cfg.round_const_23[63:32];
      end else begin
         f = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k = cfg.round_const_23[31:0];
      end
   end

   assign t        = {work_ff[0][26:0], work_ff[0][31:27]} + f + work_ff[4] + k + wt;
   assign do_round = (state_ff == sha1s_pkg::BK_ROUND) && (!loading || !q_empty);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      fresh_in     = fresh_ff;
      emit_in      = emit_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         sha1s_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_rdata.is_digest) begin
                  q_pop    = 1'b1;
                  emit_in  = '0;
                  state_in = sha1s_pkg::BK_EMIT;
               end else begin
                  rnd_in   = '0;
                  state_in = sha1s_pkg::BK_ROUND;
                  // first block of a message starts from the programmed value
                  if (fresh_ff) begin
                     work_in  = init_cv;
                     chain_in = init_cv;
                     fresh_in = 1'b0;
                  end else begin
                     work_in = chain_ff;
                  end
               end
            end
         end
         sha1s_pkg::BK_ROUND: begin
            if (do_round) begin
               q_pop = loading;
               for (int i = 0; i < sha1s_pkg::WindowLen - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[sha1s_pkg::WindowLen-1] = wt;
               work_in[0] = t;
               work_in[1] = work_ff[0];
               work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
               work_in[3] = work_ff[2];
               work_in[4] = work_ff[3];
               rnd_in     = rnd_ff + 1'b1;
               if (rnd_ff == sha1s_pkg::LAST_ROUND) begin
                  state_in = sha1s_pkg::BK_FOLD;
               end
            end
         end
         sha1s_pkg::BK_FOLD: begin
            for (int i = 0; i < sha1s_pkg::NumDigest; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = sha1s_pkg::BK_IDLE;
         end
         sha1s_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[emit_ff];
               rsp_idx_in   = emit_ff;
               rsp_last_in  = (emit_ff == sha1s_pkg::LAST_WORD_IDX);
               emit_in      = emit_ff + 1'b1;
               if (emit_ff == sha1s_pkg::LAST_WORD_IDX) begin
                  fresh_in = 1'b1;
                  state_in = sha1s_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = sha1s_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1s_pkg::BK_IDLE;
         rnd_ff       <= '0;
         fresh_ff     <= 1'b1;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         fresh_ff     <= fresh_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      chain_ff    <= chain_in;
      win_ff      <= win_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/sha1_stream_hasher.sv =====
// SHA-1 stream hasher: CSRs, byte packer front end, word queue and compression back end.
// Bytes are taken one per cycle while the 4-entry word queue has room and no padding is
// being written, also while a block is compressed; each block takes start, 80 rounds
// and fold, rounds 0-15 paced by the queue; the shared round unit sets the sustained rate.
// End of message: 3 to 18 padding/length words, one or two compressions, then five
// digest words through an output register, one per cycle while the receiver is ready.
// Reset (synchronous): clears control state and CSRs; no memory clearing pass.
`default_nettype none
module sha1_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   sha1s_pkg::cfg_type     cfg_ff, cfg_in;
   logic                   q_push, q_full, q_pop, q_empty;
   sha1s_pkg::q_entry_type q_wdata, q_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sha1s_pkg::CSR_INITIAL_AB:     cfg_in.initial_ab     = csr_wdata;
            sha1s_pkg::CSR_INITIAL_CD:     cfg_in.initial_cd     = csr_wdata;
            sha1s_pkg::CSR_INITIAL_E:      cfg_in.initial_e      = csr_wdata[31:0];
            sha1s_pkg::CSR_ROUND_CONST_01: cfg_in.round_const_01 = csr_wdata;
            sha1s_pkg::CSR_ROUND_CONST_23: cfg_in.round_const_23 = csr_wdata;
            default:                       cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sha1s_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .q_push             (q_push),
      .q_wdata            (q_wdata),
      .q_full             (q_full)
   );

   sha1s_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   sha1s_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("word queue written while full");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("word queue read while empty");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == sha1s_pkg::LAST_WORD_IDX)))
      else $error("last_word flag disagrees with word index");

endmodule
`default_nettype wire

// ===== tb/sv/sha1_digest_checker.sv =====
// Digest checker of the SHA-1 stream hasher: watches all ports, predicts and compares digests.
`timescale 1ns / 1ps
module sha1_digest_checker
   import sha1s_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_digest_word,
   input  wire logic [2:0]  rsp_word_index,
   input  wire logic        rsp_last_word,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_word_type;

   digest_word_type digest_queue [$];
   digest_word_type want;
   int              fails = 0;

   // predicted state of the hasher
   cfg_type     cfg;
   logic [7:0]  blk [64];
   int unsigned fill;
   logic [63:0] bits_done;
   word_type    chain [NumDigest];
   logic        fresh;

   function automatic word_type rol(word_type x, int n);
      return (x << n) | (x >> (WordW - n));
   endfunction

   function automatic void load_iv();
      chain[0] = cfg.initial_ab[63:32];
      chain[1] = cfg.initial_ab[31:0];
      chain[2] = cfg.initial_cd[63:32];
      chain[3] = cfg.initial_cd[31:0];
      chain[4] = cfg.initial_e;
   endfunction

   function automatic void compress_block();
      word_type w [WindowLen];
      word_type a, b, c, d, e, f, k, t, x;
      int       r;
      if (fresh) begin
         // chaining value is latched at the first compression of a message
         load_iv();
         fresh = 1'b0;
      end
      for (int i = 0; i < WindowLen; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < 80; r++) begin
         if (r >= 16) begin
            x = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
            w[r & 15] = rol(x, 1);
         end
         if (r < 20) begin
            f = (b & c) ^ (~b & d);
            k = cfg.round_const_01[63:32];
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = cfg.round_const_01[31:0];
         end else if (r < 60) begin
            f = (b & c) ^ (b & d) ^ (c & d);
            k = cfg.round_const_23[63:32];
         end else begin
            f = b ^ c ^ d;
            k = cfg.round_const_23[31:0];
         end
         t = rol(a, 5) + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   function automatic void close_message();
      int unsigned pos;
      pos = fill;
      blk[pos] = 8'h80;
      pos++;
      // no room left for the length: pad out and spend one more block
      if (pos > 56) begin
         while (pos < 64) begin
            blk[pos] = 8'h00;
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         blk[pos] = 8'h00;
         pos++;
      end
      bits_done += 64'(fill) * 64'd8;
      for (int j = 0; j < 8; j++)
         blk[63-j] = bits_done[8*j +: 8];
      compress_block();
      for (int j = 0; j < NumDigest; j++)
         digest_queue.push_back('{word: chain[j], index: 3'(j), last: (j == NumDigest - 1)});
      fill      = 0;
      bits_done = '0;
      fresh     = 1'b1;
      load_iv();
   endfunction

   function automatic void absorb_item(logic [7:0] data, logic present, logic eom);
      if (present) begin
         blk[fill] = data;
         fill++;
         if (fill >= 64) begin
            compress_block();
            bits_done += 64'd512;
            fill = 0;
         end
      end
      if (eom)
         close_message();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg       = '0;
         fill      = 0;
         bits_done = '0;
         fresh     = 1'b1;
         load_iv();
         digest_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest word: got %h", rsp_digest_word);
               fails++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_digest_word !== want.word) begin
                  $error("digest_word mismatch: expected %h, got %h", want.word,
                         rsp_digest_word);
                  fails++;
               end
               if (rsp_word_index !== want.index) begin
                  $error("word_index mismatch: expected %0d, got %0d", want.index,
                         rsp_word_index);
                  fails++;
               end
               if (rsp_last_word !== want.last) begin
                  $error("last_word mismatch: expected %0d, got %0d", want.last,
                         rsp_last_word);
                  fails++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_INITIAL_AB:     cfg.initial_ab     = csr_wdata;
               CSR_INITIAL_CD:     cfg.initial_cd     = csr_wdata;
               CSR_INITIAL_E:      cfg.initial_e      = csr_wdata[31:0];
               CSR_ROUND_CONST_01: cfg.round_const_01 = csr_wdata;
               CSR_ROUND_CONST_23: cfg.round_const_23 = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            absorb_item(req_data_byte, req_byte_present, req_end_of_message);
      end
      fail_count    <= fails;
      pending_count <= digest_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the SHA-1 stream hasher testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module testbench;
   import sha1s_pkg::*;

   localparam int SettleCycles = 300;
   localparam int HoldCycles   = 1500;
   localparam int PhaseItems   = 26;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_INITIAL_AB;
   logic [63:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int items_sent = 0;
   bit sender_steady = 1'b0;
   bit hold_now = 1'b0;

   sha1_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   sha1_digest_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 15);
      else
         return $urandom_range(30, 90);
   endfunction

   // mostly short messages, some around the one/two final block boundary, a few long
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(0, 8);
      else if (r < 80)
         return $urandom_range(9, 40);
      else if (r < 97)
         return $urandom_range(55, 65);
      else
         return $urandom_range(110, 130);
   endfunction

   task automatic send_item(logic [7:0] data, logic present, logic eom);
      int gap;
      gap = pick_gap(sender_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      if (present || eom)
         items_sent++;
   endtask

   task automatic send_message(int len);
      bit eom_on_byte;
      sender_steady = ($urandom_range(0, 3) == 0);
      eom_on_byte   = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, eom_on_byte && (i == len - 1));
      end
      if (!eom_on_byte || len == 0)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // wait out the last digest, then give the back end time to go quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic configure(cfg_type c);
      logic [2:0]  idx [6];
      logic [63:0] val [6];
      idx[0] = CSR_INITIAL_AB;     val[0] = c.initial_ab;
      idx[1] = CSR_INITIAL_CD;     val[1] = c.initial_cd;
      idx[2] = CSR_INITIAL_E;      val[2] = {$urandom, c.initial_e};
      // write to an unused index, must be ignored
      idx[3] = 3'($urandom_range(7, CSR_ROUND_CONST_23 + 1));
      val[3] = {$urandom, $urandom};
      idx[4] = CSR_ROUND_CONST_01; val[4] = c.round_const_01;
      idx[5] = CSR_ROUND_CONST_23; val[5] = c.round_const_23;
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random ready with one long hold-off once the first phase starts sending
   initial begin
      int burst;
      int gap;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && hold_now) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            held = 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 15)
               burst = $urandom_range(50, 200);
            else
               burst = $urandom_range(1, 8);
            rsp_ready <= 1'b1;
            for (int n = 0; n < burst && (held || !hold_now); n++)
               @(posedge clock);
            gap = pick_gap(1'b0);
            if (gap > 0 && (held || !hold_now)) begin
               rsp_ready <= 1'b0;
               for (int n = 0; n < gap && (held || !hold_now); n++)
                  @(posedge clock);
            end
         end
      end
   end

   initial begin
      cfg_type c;
      int      msgs;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration: empty message, idle item, byte with end,
      // end without byte after bytes, extreme byte values
      send_item(8'($urandom), 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b1);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: c = '{initial_ab:     64'h67452301_EFCDAB89,
                     initial_cd:     64'h98BADCFE_10325476,
                     initial_e:      32'hC3D2E1F0,
                     round_const_01: 64'h5A827999_6ED9EBA1,
                     round_const_23: 64'h8F1BBCDC_CA62C1D6};
            1: c = '1;
            2: c = '0;
            3: c = '{initial_ab:     '1,
                     initial_cd:     '0,
                     initial_e:      $urandom,
                     round_const_01: {$urandom, $urandom},
                     round_const_23: '1};
            default: c = '{initial_ab:     {$urandom, $urandom},
                           initial_cd:     {$urandom, $urandom},
                           initial_e:      $urandom,
                           round_const_01: {$urandom, $urandom},
                           round_const_23: {$urandom, $urandom}};
         endcase
         configure(c);
         // receiver stalls while the first phase keeps offering messages
         if (phase == 0)
            hold_now = 1'b1;
         msgs = 0;
         while (msgs == 0 || (phase == 0 && msgs < 3) ||
                items_sent < (phase + 1) * PhaseItems) begin
            send_message(pick_length());
            msgs++;
         end
         drain();
      end

      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sha1s_pkg.sv
rtl/sha1s_fifo.sv
rtl/sha1s_front.sv
rtl/sha1s_back.sv
rtl/sha1_stream_hasher.sv
tb/sv/sha1_digest_checker.sv
tb/sv/testbench.sv
